[src/c3f_pkg.sv]
// Shared constants, codes and types of the 3x3 convolution image filter.
package c3f_pkg;

   localparam int MAX_WIDTH    = 2048;
   localparam int MAX_CHANNELS = 4;
   localparam int MAX_HEIGHT   = 4096;

   localparam int SAMPLE_W = 8;
   localparam int COL_W    = $clog2(MAX_WIDTH);
   localparam int ROW_W    = $clog2(MAX_HEIGHT);
   localparam int CH_W     = $clog2(MAX_CHANNELS);

   localparam int ROW_SLOTS  = 8;
   localparam int SLOT_W     = $clog2(ROW_SLOTS);
   localparam int BANK_DEPTH = MAX_WIDTH * MAX_CHANNELS;
   localparam int ADDR_W     = $clog2(BANK_DEPTH);

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam int WIDTH_REG_W  = 12;
   localparam int HEIGHT_REG_W = 13;
   localparam int CHAN_REG_W   = 3;
   localparam int KSEL_W       = 3;

   localparam logic [WIDTH_REG_W-1:0]  WIDTH_LIMIT  = WIDTH_REG_W'(MAX_WIDTH);
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_LIMIT = HEIGHT_REG_W'(MAX_HEIGHT);
   localparam logic [CHAN_REG_W-1:0]   CHAN_LIMIT   = CHAN_REG_W'(MAX_CHANNELS);

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam int ACC_W      = 14;
   localparam int BOX_IN_W   = 12;
   localparam int BOX_RECIP  = 7282;
   localparam int BOX_SHIFT  = 16;
   localparam int BOX_PROD_W = 25;

   typedef enum logic [1:0] {
      REG_WIDTH  = 2'd0,
      REG_HEIGHT = 2'd1,
      REG_CHANS  = 2'd2,
      REG_KERNEL = 2'd3
   } reg_index_type;

   localparam logic [KSEL_W-1:0] KERNEL_EDGE     = 3'd0;
   localparam logic [KSEL_W-1:0] KERNEL_SHARPEN  = 3'd1;
   localparam logic [KSEL_W-1:0] KERNEL_BOX      = 3'd2;
   localparam logic [KSEL_W-1:0] KERNEL_GAUSS    = 3'd3;
   localparam logic [KSEL_W-1:0] KERNEL_EMBOSS   = 3'd4;
   localparam logic [KSEL_W-1:0] KERNEL_IDENTITY = 3'd5;

   typedef struct packed {
      logic [WIDTH_REG_W-1:0]  img_width;
      logic [HEIGHT_REG_W-1:0] img_height;
      logic [CHAN_REG_W-1:0]   chan_count;
      logic [KSEL_W-1:0]       kernel_sel;
   } cfg_type;

   typedef struct packed {
      logic                en;
      logic [SLOT_W-1:0]   slot;
      logic [ADDR_W-1:0]   addr;
      logic [SAMPLE_W-1:0] data;
   } wr_type;

   typedef struct packed {
      logic [COL_W-1:0]            col_r;
      logic [CH_W-1:0]             ch;
      logic                        first;
      logic [2:0][SLOT_W-1:0]      slot;
      logic                        last;
   } token_type;

endpackage

[src/c3f_req_if.sv]
// Input channel of the filter: one sample or drain beat.
interface c3f_req_if;
   import c3f_pkg::*;
   logic                valid;
   logic                ready;
   logic                op;
   logic [SAMPLE_W-1:0] sample;
   modport source (output valid, output op, output sample, input ready);
   modport sink (input valid, input op, input sample, output ready);
endinterface

[src/c3f_rsp_if.sv]
// Result channel of the filter: one filtered byte per beat.
interface c3f_rsp_if;
   import c3f_pkg::*;
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] filtered;
   logic                frame_end;
   modport source (output valid, output filtered, output frame_end, input ready);
   modport sink (input valid, input filtered, input frame_end, output ready);
endinterface

[src/c3f_ram.sv]
// Generic single-write, dual-read memory with registered read data.
module c3f_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;
endmodule

[src/c3f_front.sv]
// Front end: register file, input and output position tracking, line writes and tokens.
module c3f_front (
   input  logic                            clock,
   input  logic                            reset,
   c3f_req_if.sink                         req_bus,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [c3f_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [c3f_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [c3f_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready,
   output c3f_pkg::cfg_type                cfg,
   output c3f_pkg::wr_type                 wr,
   output c3f_pkg::token_type              tok,
   output logic                            tok_push,
   input  logic                            q_full,
   input  logic                            q_empty
);
   import c3f_pkg::*;

   cfg_type                 cfg_ff, cfg_in;
   logic [COL_W-1:0]        in_col_ff, in_col_in;
   logic [ROW_W-1:0]        in_row_ff, in_row_in;
   logic [CH_W-1:0]         in_ch_ff, in_ch_in;
   logic                    done_ff, done_in;
   logic [COL_W-1:0]        o_x_ff, o_x_in;
   logic [ROW_W-1:0]        o_y_ff, o_y_in;
   logic [CH_W-1:0]         o_ch_ff, o_ch_in;

   reg_index_type           reg_idx;
   logic                    csr_wr;
   logic                    restart;
   logic [WIDTH_REG_W-1:0]  v_width;
   logic [HEIGHT_REG_W-1:0] v_height;
   logic [CHAN_REG_W-1:0]   v_chans;
   logic [WIDTH_REG_W-1:0]  wm1;
   logic [HEIGHT_REG_W-1:0] hm1;
   logic [CHAN_REG_W-1:0]   cm1;
   logic                    at_start;
   logic                    accept;
   logic                    do_push;
   logic                    do_emit;
   logic                    warm;
   logic                    x_end, y_end, c_end;

   assign reg_idx    = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign v_width    = csr_pwdata[WIDTH_REG_W-1:0];
   assign v_height   = csr_pwdata[HEIGHT_REG_W-1:0];
   assign v_chans    = csr_pwdata[CHAN_REG_W-1:0];

   always_comb begin
      cfg_in  = cfg_ff;
      restart = csr_wr;
      if (csr_wr) begin
         unique case (reg_idx)
            REG_WIDTH: begin
               cfg_in.img_width = (v_width == '0) ? WIDTH_REG_W'(1) :
                                  ((v_width > WIDTH_LIMIT) ? WIDTH_LIMIT : v_width);
            end
            REG_HEIGHT: begin
               cfg_in.img_height = (v_height == '0) ? HEIGHT_REG_W'(1) :
                                   ((v_height > HEIGHT_LIMIT) ? HEIGHT_LIMIT : v_height);
            end
            REG_CHANS: begin
               cfg_in.chan_count = (v_chans == '0) ? CHAN_REG_W'(1) :
                                   ((v_chans > CHAN_LIMIT) ? CHAN_LIMIT : v_chans);
            end
            REG_KERNEL: begin
               cfg_in.kernel_sel = csr_pwdata[KSEL_W-1:0];
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_WIDTH:  csr_prdata = CSR_DATA_W'(cfg_ff.img_width);
         REG_HEIGHT: csr_prdata = CSR_DATA_W'(cfg_ff.img_height);
         REG_CHANS:  csr_prdata = CSR_DATA_W'(cfg_ff.chan_count);
         REG_KERNEL: csr_prdata = CSR_DATA_W'(cfg_ff.kernel_sel);
      endcase
   end

   assign wm1 = cfg_ff.img_width - 1'b1;
   assign hm1 = cfg_ff.img_height - 1'b1;
   assign cm1 = cfg_ff.chan_count - 1'b1;

   // A new frame waits until the previous frame's tokens have read the line store.
   assign at_start = (in_col_ff == '0) && (in_row_ff == '0) && (in_ch_ff == '0) && !done_ff;
   assign req_bus.ready = !q_full && !(at_start && !q_empty);
   assign accept  = req_bus.valid && req_bus.ready;
   assign do_push = accept && !req_bus.op && !done_ff;
   assign warm    = (|in_row_ff[ROW_W-1:1]) || ((in_row_ff == ROW_W'(1)) && (in_col_ff != '0));
   assign do_emit = accept && (done_ff || (do_push && warm));

   assign x_end = ({1'b0, o_x_ff} == wm1);
   assign y_end = ({1'b0, o_y_ff} == hm1);
   assign c_end = ({1'b0, o_ch_ff} == cm1);

   always_comb begin
      tok.col_r   = x_end ? o_x_ff : o_x_ff + 1'b1;
      tok.ch      = o_ch_ff;
      tok.first   = (o_x_ff == '0);
      tok.slot[0] = (o_y_ff == '0) ? o_y_ff[SLOT_W-1:0] : SLOT_W'(o_y_ff - 1'b1);
      tok.slot[1] = o_y_ff[SLOT_W-1:0];
      tok.slot[2] = y_end ? o_y_ff[SLOT_W-1:0] : SLOT_W'(o_y_ff + 1'b1);
      tok.last    = x_end && y_end && c_end;
   end
   assign tok_push = do_emit;

   assign wr.en   = do_push;
   assign wr.slot = in_row_ff[SLOT_W-1:0];
   assign wr.addr = {in_col_ff, in_ch_ff};
   assign wr.data = req_bus.sample;

   always_comb begin
      in_col_in = in_col_ff;
      in_row_in = in_row_ff;
      in_ch_in  = in_ch_ff;
      done_in   = done_ff;
      o_x_in    = o_x_ff;
      o_y_in    = o_y_ff;
      o_ch_in   = o_ch_ff;
      if (restart) begin
         in_col_in = '0;
         in_row_in = '0;
         in_ch_in  = '0;
         done_in   = 1'b0;
         o_x_in    = '0;
         o_y_in    = '0;
         o_ch_in   = '0;
      end else begin
         if (do_push) begin
            if ({1'b0, in_ch_ff} == cm1) begin
               in_ch_in = '0;
               if ({1'b0, in_col_ff} == wm1) begin
                  in_col_in = '0;
                  if ({1'b0, in_row_ff} == hm1) begin
                     in_row_in = '0;
                     done_in   = 1'b1;
                  end else begin
                     in_row_in = in_row_ff + 1'b1;
                  end
               end else begin
                  in_col_in = in_col_ff + 1'b1;
               end
            end else begin
               in_ch_in = in_ch_ff + 1'b1;
            end
         end
         if (do_emit) begin
            if (tok.last) begin
               o_x_in  = '0;
               o_y_in  = '0;
               o_ch_in = '0;
               done_in = 1'b0;
            end else if (c_end) begin
               o_ch_in = '0;
               if (x_end) begin
                  o_x_in = '0;
                  o_y_in = o_y_ff + 1'b1;
               end else begin
                  o_x_in = o_x_ff + 1'b1;
               end
            end else begin
               o_ch_in = o_ch_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.img_width  <= WIDTH_REG_W'(1);
         cfg_ff.img_height <= HEIGHT_REG_W'(1);
         cfg_ff.chan_count <= CHAN_REG_W'(1);
         cfg_ff.kernel_sel <= KERNEL_IDENTITY;
         in_col_ff <= '0;
         in_row_ff <= '0;
         in_ch_ff  <= '0;
         done_ff   <= 1'b0;
         o_x_ff    <= '0;
         o_y_ff    <= '0;
         o_ch_ff   <= '0;
      end else begin
         cfg_ff    <= cfg_in;
         in_col_ff <= in_col_in;
         in_row_ff <= in_row_in;
         in_ch_ff  <= in_ch_in;
         done_ff   <= done_in;
         o_x_ff    <= o_x_in;
         o_y_ff    <= o_y_in;
         o_ch_ff   <= o_ch_in;
      end
   end

   assign cfg = cfg_ff;
endmodule

[src/c3f_queue.sv]
// Short token queue between the front end and the back end.
module c3f_queue (
   input  logic               clock,
   input  logic               reset,
   input  c3f_pkg::token_type push_data,
   input  logic               push,
   input  logic               pop,
   output c3f_pkg::token_type head,
   output logic               full,
   output logic               empty
);
   import c3f_pkg::*;

   token_type         entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wp_ff, wp_in;
   logic [QPTR_W-1:0] rp_ff, rp_in;
   logic [QPTR_W:0]   cnt_ff, cnt_in;

   assign full  = (cnt_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign empty = (cnt_ff == '0);
   assign head  = entry_ff[rp_ff];

   always_comb begin
      wp_in  = push ? wp_ff + 1'b1 : wp_ff;
      rp_in  = pop ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wp_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full) else $error("Token queue written while full.");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty) else $error("Token queue read while empty.");
   a_push_fills: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> !empty) else $error("Token queue lost a pushed entry.");
endmodule

[src/c3f_back.sv]
// Back end: line store banks, per-channel window, kernel arithmetic and result register.
module c3f_back (
   input  logic               clock,
   input  logic               reset,
   input  c3f_pkg::cfg_type   cfg,
   input  c3f_pkg::wr_type    wr,
   input  c3f_pkg::token_type head,
   input  logic               q_empty,
   output logic               pop,
   c3f_rsp_if.source          rsp_bus
);
   import c3f_pkg::*;

   logic [SAMPLE_W-1:0]     rd_a [ROW_SLOTS];
   logic [SAMPLE_W-1:0]     rd_b [ROW_SLOTS];
   logic [ADDR_W-1:0]       addr_a, addr_b;
   logic                    adv;

   logic                    s1_valid_ff;
   token_type               s1_tok_ff;
   logic [SAMPLE_W-1:0]     ctr_ff [MAX_CHANNELS][3];
   logic [SAMPLE_W-1:0]     rgt_ff [MAX_CHANNELS][3];
   logic [SAMPLE_W-1:0]     win [3][3];
   logic signed [ACC_W-1:0] p [3][3];
   logic signed [ACC_W-1:0] nsum, val_in;
   logic                    box_in;

   logic                    s2_valid_ff;
   logic signed [ACC_W-1:0] s2_val_ff;
   logic                    s2_box_ff;
   logic                    s2_last_ff;

   logic [BOX_PROD_W-1:0]   box_prod;
   logic [SAMPLE_W-1:0]     res_in;
   logic                    s3_valid_ff;
   logic [SAMPLE_W-1:0]     s3_val_ff;
   logic                    s3_last_ff;

   assign adv    = !s3_valid_ff || rsp_bus.ready;
   assign pop    = adv && !q_empty;
   assign addr_a = {COL_W'(0), head.ch};
   assign addr_b = {head.col_r, head.ch};

   for (genvar b = 0; b < ROW_SLOTS; b++) begin : g_bank
      c3f_ram #(.WIDTH(SAMPLE_W), .DEPTH(BANK_DEPTH)) u_ram (
         .clock     (clock),
         .wr_en     (wr.en && (wr.slot == SLOT_W'(b))),
         .wr_addr   (wr.addr),
         .wr_data   (wr.data),
         .rd_en     (pop),
         .rd_addr_a (addr_a),
         .rd_addr_b (addr_b),
         .rd_data_a (rd_a[b]),
         .rd_data_b (rd_b[b])
      );
   end

   // At the start of a row the left and center columns both take column zero.
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         win[r][0] = s1_tok_ff.first ? rd_a[s1_tok_ff.slot[r]] : ctr_ff[s1_tok_ff.ch][r];
         win[r][1] = s1_tok_ff.first ? rd_a[s1_tok_ff.slot[r]] : rgt_ff[s1_tok_ff.ch][r];
         win[r][2] = rd_b[s1_tok_ff.slot[r]];
         for (int c = 0; c < 3; c++) begin
            p[r][c] = $signed(ACC_W'(win[r][c]));
         end
      end
   end

   assign nsum = p[0][1] + p[1][0] + p[1][2] + p[2][1];

   always_comb begin
      box_in = 1'b0;
      unique case (cfg.kernel_sel)
         KERNEL_EDGE:    val_in = (p[1][1] <<< 2) - nsum;
         KERNEL_SHARPEN: val_in = (p[1][1] <<< 2) + p[1][1] - nsum;
         KERNEL_BOX: begin
            val_in = p[0][0] + p[0][2] + p[2][0] + p[2][2] + nsum + p[1][1];
            box_in = 1'b1;
         end
         KERNEL_GAUSS:
            val_in = (p[0][0] + p[0][2] + p[2][0] + p[2][2] + (nsum <<< 1)
                      + (p[1][1] <<< 2)) >>> 4;
         KERNEL_EMBOSS:
            val_in = p[1][1] + p[1][2] + p[2][1] + (p[2][2] <<< 1)
                     - p[0][1] - p[1][0] - (p[0][0] <<< 1);
         default:        val_in = p[1][1];
      endcase
   end

   assign box_prod = BOX_PROD_W'(s2_val_ff[BOX_IN_W-1:0]) * BOX_PROD_W'(BOX_RECIP);

   always_comb begin
      if (s2_box_ff) begin
         res_in = box_prod[BOX_SHIFT+SAMPLE_W-1:BOX_SHIFT];
      end else if (s2_val_ff <= 0) begin
         res_in = '0;
      end else if (s2_val_ff > $signed(ACC_W'(255))) begin
         res_in = '1;
      end else begin
         res_in = s2_val_ff[SAMPLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s1_tok_ff <= head;
      end
      if (adv && s1_valid_ff) begin
         for (int r = 0; r < 3; r++) begin
            ctr_ff[s1_tok_ff.ch][r] <= win[r][1];
            rgt_ff[s1_tok_ff.ch][r] <= win[r][2];
         end
         s2_val_ff  <= val_in;
         s2_box_ff  <= box_in;
         s2_last_ff <= s1_tok_ff.last;
      end
      if (adv && s2_valid_ff) begin
         s3_val_ff  <= res_in;
         s3_last_ff <= s2_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= pop;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   assign rsp_bus.valid     = s3_valid_ff;
   assign rsp_bus.filtered  = s3_val_ff;
   assign rsp_bus.frame_end = s3_last_ff;
endmodule

[src/conv3x3_image_filter.sv]
// Top level of the 3x3 convolution image filter.
// Usage: channel bytes of a frame enter on req_bus in raster order, channels
// interleaved. A beat with op 0 pushes a sample, op 1 drains one pending
// result once the whole frame has arrived. Results leave on rsp_bus, with
// frame_end set on the last byte of the frame. Registers for width, height,
// channel count and kernel are written over the csr_ port while the block is
// idle; any write restarts the frame.
// The result for byte q is caused by the push of byte q + (width + 1) * channels,
// or by a drain, and passes the token queue and the s1, s2 and s3 registers
// on its way to rsp_bus. One beat is accepted per cycle while the token queue
// has room; the line store banks read a full window column per cycle, so the
// back end keeps pace unless rsp_bus stalls. The first beat of a frame waits
// until the token queue has emptied, which takes longer while rsp_bus stalls.
// After reset the registers hold width 1, height 1, one channel and identity,
// and the frame starts fresh. When rsp_bus stalls, the output stages hold and
// the four-entry token queue keeps taking beats until it fills.
module conv3x3_image_filter (
   input  logic                            clock,
   input  logic                            reset,
   c3f_req_if.sink                         req_bus,
   c3f_rsp_if.source                       rsp_bus,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [c3f_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [c3f_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [c3f_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import c3f_pkg::*;

   cfg_type   cfg;
   wr_type    wr;
   token_type tok;
   token_type head;
   logic      tok_push;
   logic      pop;
   logic      q_full;
   logic      q_empty;

   c3f_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg),
      .wr          (wr),
      .tok         (tok),
      .tok_push    (tok_push),
      .q_full      (q_full),
      .q_empty     (q_empty)
   );

   c3f_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_data (tok),
      .push      (tok_push),
      .pop       (pop),
      .head      (head),
      .full      (q_full),
      .empty     (q_empty)
   );

   c3f_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .wr      (wr),
      .head    (head),
      .q_empty (q_empty),
      .pop     (pop),
      .rsp_bus (rsp_bus)
   );
endmodule

[test/tb.sv]
// Self-checking testbench of the 3x3 convolution image filter with a scoreboard predictor.
module tb;
   import c3f_pkg::*;

   localparam logic OP_PUSH  = 1'b0;
   localparam logic OP_DRAIN = 1'b1;
   localparam int   CYCLE_LIMIT = 2000000;
   localparam int   STORE_ROW   = MAX_WIDTH * MAX_CHANNELS;

   typedef struct {
      logic [SAMPLE_W-1:0] filtered;
      logic                frame_end;
   } pixel_result_type;

   class filter_scoreboard;
      int unsigned img_w, img_h, chans, ksel;
      int unsigned col, row, chn, out_pos;
      bit          frame_in;
      byte unsigned store [4*STORE_ROW];
      pixel_result_type pending [$];
      int errors;

      function new();
         img_w = 1;
         img_h = 1;
         chans = 1;
         ksel = KERNEL_IDENTITY;
         errors = 0;
         restart();
      endfunction

      function void restart();
         col = 0;
         row = 0;
         chn = 0;
         out_pos = 0;
         frame_in = 0;
      endfunction

      function int unsigned clamp(int unsigned v, int unsigned hi);
         if (v == 0) return 1;
         if (v > hi) return hi;
         return v;
      endfunction

      function void write_reg(reg_index_type idx, logic [31:0] value);
         case (idx)
            REG_WIDTH: img_w = clamp(value[11:0], MAX_WIDTH);
            REG_HEIGHT: img_h = clamp(value[12:0], MAX_HEIGHT);
            REG_CHANS: chans = clamp(value[2:0], MAX_CHANNELS);
            REG_KERNEL: ksel = value[2:0];
         endcase
         restart();
      endfunction

      function int coef(int unsigned k, int i);
         int tbl [6][9] = '{
            '{0, -144, 0, -144, 576, -144, 0, -144, 0},
            '{0, -144, 0, -144, 720, -144, 0, -144, 0},
            '{16, 16, 16, 16, 16, 16, 16, 16, 16},
            '{9, 18, 9, 18, 36, 18, 9, 18, 9},
            '{-288, -144, 0, -144, 144, 144, 0, 144, 288},
            '{0, 0, 0, 0, 144, 0, 0, 0, 0}};
         return tbl[k][i];
      endfunction

      function void filter_next();
         int unsigned c, pix, ox, oy, k, v;
         int unsigned xs [3];
         int unsigned ys [3];
         int sum;
         pixel_result_type r;
         c = out_pos % chans;
         pix = out_pos / chans;
         ox = pix % img_w;
         oy = pix / img_w;
         k = (ksel < 6) ? ksel : KERNEL_IDENTITY;
         xs[0] = (ox > 0) ? ox - 1 : 0;
         xs[1] = ox;
         xs[2] = (ox + 1 < img_w) ? ox + 1 : img_w - 1;
         ys[0] = (oy > 0) ? oy - 1 : 0;
         ys[1] = oy;
         ys[2] = (oy + 1 < img_h) ? oy + 1 : img_h - 1;
         sum = 0;
         for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
               sum += coef(k, i*3 + j) * int'(store[(ys[i] & 3)*STORE_ROW + xs[j]*4 + c]);
         if (sum <= 0) v = 0;
         else begin
            v = sum / 144;
            if (v > 255) v = 255;
         end
         r.filtered = v[7:0];
         r.frame_end = (out_pos + 1 >= img_w * img_h * chans);
         pending.push_back(r);
         if (r.frame_end) restart();
         else out_pos++;
      endfunction

      function void note_beat(logic op, logic [SAMPLE_W-1:0] smp);
         int unsigned q;
         if (op == OP_DRAIN || frame_in) begin
            if (frame_in) filter_next();
            return;
         end
         store[(row & 3)*STORE_ROW + col*4 + chn] = smp;
         q = (row * img_w + col) * chans + chn;
         chn++;
         if (chn >= chans) begin
            chn = 0;
            col++;
            if (col >= img_w) begin
               col = 0;
               row++;
               if (row >= img_h) begin
                  row = 0;
                  frame_in = 1;
               end
            end
         end
         if (q >= (img_w + 1) * chans) filter_next();
      endfunction

      function void check_beat(logic [SAMPLE_W-1:0] filtered, logic frame_end);
         pixel_result_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result filtered=%0d frame_end=%0d",
                     $time, filtered, frame_end);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (filtered !== e.filtered) begin
            $display("%0t: filtered expected %0d actual %0d", $time, e.filtered, filtered);
            errors++;
         end
         if (frame_end !== e.frame_end) begin
            $display("%0t: frame_end expected %0d actual %0d", $time, e.frame_end, frame_end);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata, csr_prdata;
   logic csr_pready;

   c3f_req_if req ();
   c3f_rsp_if rsp ();

   conv3x3_image_filter dut (
      .clock(clock), .reset(reset), .req_bus(req), .rsp_bus(rsp),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   filter_scoreboard sb;
   int src_idle, sink_idle, hold_cycles, cycles, beats_sent;
   bit hold_req;

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 0;
      end else if (hold_req) begin
         hold_req <= 0;
         hold_cycles <= 300;
         rsp.ready <= 0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp.ready <= 0;
      end else begin
         rsp.ready <= ($urandom_range(99) >= sink_idle);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) sb.check_beat(rsp.filtered, rsp.frame_end);
   end

   task automatic send_beat(logic op, logic [SAMPLE_W-1:0] smp);
      if ($urandom_range(99) < src_idle) begin
         req.valid <= 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req.valid <= 1;
      req.op <= op;
      req.sample <= smp;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      sb.note_beat(op, smp);
      beats_sent++;
   endtask

   task automatic wait_idle();
      req.valid <= 0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_reg(reg_index_type idx, logic [31:0] value);
      csr_psel <= 1;
      csr_penable <= 0;
      csr_pwrite <= 1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      sb.write_reg(idx, value);
      @(posedge clock);
   endtask

   task automatic configure(int unsigned w, int unsigned h, int unsigned c, int unsigned k);
      wait_idle();
      write_reg(REG_WIDTH, w);
      write_reg(REG_HEIGHT, h);
      write_reg(REG_CHANS, c);
      write_reg(REG_KERNEL, k);
   endtask

   // Pushes a share of one frame with a few early drains mixed in; a full frame
   // is then flushed by drains, with some pushes that act as drains.
   task automatic run_frame(int pct);
      int unsigned total, n;
      total = sb.img_w * sb.img_h * sb.chans;
      n = 0;
      while (n < total * pct / 100) begin
         if ($urandom_range(99) < 4) begin
            send_beat(OP_DRAIN, $urandom_range(255));
         end else begin
            send_beat(OP_PUSH, $urandom_range(255));
            n++;
         end
      end
      if (pct == 100)
         while (sb.frame_in)
            send_beat(($urandom_range(99) < 80) ? OP_DRAIN : OP_PUSH, $urandom_range(255));
   endtask

   initial begin
      sb = new();
      reset = 1;
      req.valid = 0;
      req.op = 0;
      req.sample = 0;
      rsp.ready = 0;
      csr_psel = 0;
      csr_penable = 0;
      csr_pwrite = 0;
      csr_paddr = 0;
      csr_pwdata = 0;
      src_idle = 14;
      sink_idle = 84;
      hold_req = 0;
      hold_cycles = 0;
      cycles = 0;
      beats_sent = 0;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      send_beat(OP_DRAIN, 8'hFF);
      send_beat(OP_PUSH, 8'hFF);
      send_beat(OP_DRAIN, 8'h00);
      send_beat(OP_DRAIN, 8'h00);
      configure(0, 0, 0, 7);
      send_beat(OP_PUSH, 8'h00);
      send_beat(OP_DRAIN, 8'hFF);
      configure(2, 1, 3, KERNEL_SHARPEN);
      send_beat(OP_DRAIN, 8'h00);
      for (int i = 0; i < 6; i++) send_beat(OP_PUSH, (i % 2) ? 8'hFF : 8'h00);
      for (int i = 0; i < 7; i++) send_beat(OP_DRAIN, 8'h55);
      configure(2, 2, 1, KERNEL_EMBOSS);
      send_beat(OP_PUSH, 8'hFF);
      send_beat(OP_PUSH, 8'hFF);
      send_beat(OP_PUSH, 8'h00);
      send_beat(OP_PUSH, 8'h00);
      while (sb.frame_in) send_beat(OP_DRAIN, 8'h00);

      while (beats_sent < 500) begin
         if (beats_sent >= 170 && src_idle == 14) begin
            src_idle = 84;
            sink_idle = 14;
         end
         if (beats_sent >= 340 && src_idle != 0) begin
            configure(6, 5, 2, KERNEL_GAUSS);
            src_idle = 0;
            sink_idle = 0;
            hold_req = 1;
            run_frame(100);
         end else begin
            configure(($urandom_range(9) == 0) ? 0 : $urandom_range(1, 6),
                      ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 5),
                      $urandom_range(0, 7), $urandom_range(0, 7));
            repeat ($urandom_range(1, 3)) run_frame(($urandom_range(7) == 0) ? 50 : 100);
         end
      end

      configure(4095, 2, 1, KERNEL_GAUSS);
      run_frame(1);
      configure(1, 8191, 1, KERNEL_BOX);
      run_frame(2);
      configure(MAX_WIDTH, 1, 4, KERNEL_EDGE);
      run_frame(1);

      wait_idle();
      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
